// ===== src/stereo_predictive_residual_encoder_assert.svh =====
`ifndef STEREO_PREDICTIVE_RESIDUAL_ENCODER_ASSERT_SVH
`define STEREO_PREDICTIVE_RESIDUAL_ENCODER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPL(name, clk, rst_n, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(name, clk, rst_n, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== src/spre_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spre_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PARAM_W  = 15;
  localparam int SUM_W    = 32;
  // Widest pair count of a block: the block counter allows up to 32 bits.
  localparam int LEN_W    = 33;
  // 19 * sum and 20 * len.
  localparam int NUM_W    = SUM_W + 5;
  localparam int DEN_W    = LEN_W + 5;

  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = 1;

  localparam logic [PARAM_W-1:0] PARAM_MIN = 15'd1;
  localparam logic [PARAM_W-1:0] PARAM_MAX = 15'h7fff;

  localparam logic [2:0]  PREDICTOR_MODE_RESET = 3'd2;
  localparam logic [1:0]  CHANNEL_MODE_RESET   = 2'd0;
  localparam logic        ADAPTIVE_PARAM_RESET = 1'b1;
  localparam logic [15:0] FIXED_PARAM_RESET    = 16'd0;
  localparam logic [15:0] BLOCK_LENGTH_RESET   = 16'd1024;

  typedef enum logic [2:0] {
    CFG_PREDICTOR_MODE = 3'd0,
    CFG_CHANNEL_MODE   = 3'd1,
    CFG_ADAPTIVE_PARAM = 3'd2,
    CFG_FIXED_PARAM    = 3'd3,
    CFG_BLOCK_LENGTH   = 3'd4
  } cfg_index_e;

  typedef enum logic [2:0] {
    PRED_NONE     = 3'd0,
    PRED_ORDER1   = 3'd1,
    PRED_ORDER2   = 3'd2,
    PRED_ORDER3   = 3'd3,
    PRED_ADAPTIVE = 3'd4
  } pred_mode_e;

  typedef enum logic [1:0] {
    CHAN_INDEPENDENT = 2'd0,
    CHAN_MID_SIDE    = 2'd1,
    CHAN_LEFT_SIDE   = 2'd2
  } chan_mode_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_OUT
  } back_state_e;

  typedef struct packed {
    logic [2:0]  predictor_mode;
    logic [1:0]  channel_mode;
    logic        adaptive_param;
    logic [15:0] fixed_param;
    logic [15:0] block_length;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] first_residual;
    logic signed [SAMPLE_W-1:0] second_residual;
    logic                       block_end;
    logic [PARAM_W-1:0]         first_param;
    logic [PARAM_W-1:0]         second_param;
  } out_item_t;

  // One classified pair handed from the front to the back.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] first_residual;
    logic signed [SAMPLE_W-1:0] second_residual;
    logic                       closes;
    logic                       use_div;
    logic [PARAM_W-1:0]         fixed_param;
    logic [SUM_W-1:0]           first_sum;
    logic [SUM_W-1:0]           second_sum;
    logic [LEN_W-1:0]           len;
  } job_t;

endpackage

`default_nettype wire

// ===== src/spre_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spre_front #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire spre_pkg::cfg_t    cfg_i,
  input  wire logic              in_valid_i,
  input  wire spre_pkg::in_item_t in_data_i,
  output logic                   push_valid_o,
  input  wire logic              push_ready_i,
  output spre_pkg::job_t         job_o
);
  import spre_pkg::*;

  localparam int CMP_W = (COUNT_BITS + 1 > 16) ? COUNT_BITS + 1 : 16;

  function automatic logic [SAMPLE_W-1:0] predict(
    input logic [2:0]          mode,
    input logic [1:0]          n,
    input logic [SAMPLE_W-1:0] h1,
    input logic [SAMPLE_W-1:0] h2,
    input logic [SAMPLE_W-1:0] h3
  );
    logic [SAMPLE_W-1:0] o2;
    logic [SAMPLE_W-1:0] o3;
    logic [SAMPLE_W-1:0] p;
    o2 = {h1[SAMPLE_W-2:0], 1'b0} - h2;
    o3 = {h1[SAMPLE_W-2:0], 1'b0} + h1 - {h2[SAMPLE_W-2:0], 1'b0} - h2 + h3;
    unique case (pred_mode_e'(mode))
      PRED_ORDER1:   p = h1;
      PRED_ORDER2:   p = (n < 2'd2) ? h1 : o2;
      PRED_ORDER3:   p = (n < 2'd2) ? h1 : ((n == 2'd2) ? o2 : o3);
      // The adaptive choice settles on order one once three samples are known.
      PRED_ADAPTIVE: p = (n < 2'd2) ? h1 : ((n == 2'd2) ? o2 : h1);
      default:       p = '0;
    endcase
    if (n == 2'd0) begin
      p = '0;
    end
    return p;
  endfunction

  logic [SAMPLE_W-1:0]   first_hist_q [3];
  logic [SAMPLE_W-1:0]   second_hist_q [3];
  logic [1:0]            seen_q;
  logic [COUNT_BITS-1:0] pos_q;
  logic [SUM_W-1:0]      first_sum_q;
  logic [SUM_W-1:0]      second_sum_q;

  logic                  accept;
  logic [SAMPLE_W:0]     pair_sum;
  logic [SAMPLE_W:0]     pair_adj;
  logic [SAMPLE_W-1:0]   side;
  logic [SAMPLE_W-1:0]   first_smp;
  logic [SAMPLE_W-1:0]   second_smp;
  logic [SAMPLE_W-1:0]   first_res;
  logic [SAMPLE_W-1:0]   second_res;
  logic [SAMPLE_W:0]     first_abs;
  logic [SAMPLE_W:0]     second_abs;
  logic [SUM_W-1:0]      first_sum_d;
  logic [SUM_W-1:0]      second_sum_d;
  logic [COUNT_BITS:0]   len;
  logic                  closes;
  logic [PARAM_W-1:0]    fixed_clamped;

  assign accept = in_valid_i && push_ready_i;

  always_comb begin
    pair_sum = {in_data_i.left_sample[SAMPLE_W-1], in_data_i.left_sample}
             + {in_data_i.right_sample[SAMPLE_W-1], in_data_i.right_sample};
    // Adding one to a negative sum makes the halving round toward zero.
    pair_adj = pair_sum + {{SAMPLE_W{1'b0}}, pair_sum[SAMPLE_W]};
    side     = in_data_i.left_sample - in_data_i.right_sample;
    case (chan_mode_e'(cfg_i.channel_mode))
      CHAN_MID_SIDE: begin
        first_smp  = pair_adj[SAMPLE_W:1];
        second_smp = side;
      end
      CHAN_LEFT_SIDE: begin
        first_smp  = in_data_i.left_sample;
        second_smp = side;
      end
      default: begin
        first_smp  = in_data_i.left_sample;
        second_smp = in_data_i.right_sample;
      end
    endcase

    first_res  = first_smp - predict(cfg_i.predictor_mode, seen_q, first_hist_q[0],
                                     first_hist_q[1], first_hist_q[2]);
    second_res = second_smp - predict(cfg_i.predictor_mode, seen_q, second_hist_q[0],
                                      second_hist_q[1], second_hist_q[2]);
    first_abs  = first_res[SAMPLE_W-1] ? ({(SAMPLE_W+1){1'b0}} - {1'b1, first_res})
                                       : {1'b0, first_res};
    second_abs = second_res[SAMPLE_W-1] ? ({(SAMPLE_W+1){1'b0}} - {1'b1, second_res})
                                        : {1'b0, second_res};
    first_sum_d  = first_sum_q + SUM_W'(first_abs);
    second_sum_d = second_sum_q + SUM_W'(second_abs);

    len    = {1'b0, pos_q} + (COUNT_BITS+1)'(1);
    closes = in_data_i.end_of_stream || (CMP_W'(len) >= CMP_W'(cfg_i.block_length))
             || (&pos_q);

    if (cfg_i.fixed_param == 16'd0) begin
      fixed_clamped = PARAM_MIN;
    end else if (cfg_i.fixed_param[15]) begin
      fixed_clamped = PARAM_MAX;
    end else begin
      fixed_clamped = cfg_i.fixed_param[PARAM_W-1:0];
    end
  end

  assign push_valid_o          = in_valid_i;
  assign job_o.first_residual  = first_res;
  assign job_o.second_residual = second_res;
  assign job_o.closes          = closes;
  assign job_o.use_div         = closes && cfg_i.adaptive_param;
  assign job_o.fixed_param     = fixed_clamped;
  assign job_o.first_sum       = first_sum_d;
  assign job_o.second_sum      = second_sum_d;
  assign job_o.len             = LEN_W'(len);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        first_hist_q[i]  <= '0;
        second_hist_q[i] <= '0;
      end
      seen_q       <= '0;
      pos_q        <= '0;
      first_sum_q  <= '0;
      second_sum_q <= '0;
    end else if (accept) begin
      if (in_data_i.end_of_stream) begin
        for (int i = 0; i < 3; i++) begin
          first_hist_q[i]  <= '0;
          second_hist_q[i] <= '0;
        end
        seen_q <= '0;
      end else begin
        first_hist_q[2]  <= first_hist_q[1];
        first_hist_q[1]  <= first_hist_q[0];
        first_hist_q[0]  <= first_smp;
        second_hist_q[2] <= second_hist_q[1];
        second_hist_q[1] <= second_hist_q[0];
        second_hist_q[0] <= second_smp;
        if (seen_q != 2'd3) begin
          seen_q <= seen_q + 2'd1;
        end
      end
      if (closes) begin
        pos_q        <= '0;
        first_sum_q  <= '0;
        second_sum_q <= '0;
      end else begin
        pos_q        <= len[COUNT_BITS-1:0];
        first_sum_q  <= first_sum_d;
        second_sum_q <= second_sum_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/spre_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spre_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  wire spre_pkg::job_t push_data_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output spre_pkg::job_t      pop_data_o
);
  import spre_pkg::*;

  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  job_t               entry_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q;
  logic [Q_PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0]   count_q;
  logic               push;
  logic               pop;

  assign push_ready_o = (count_q != CNT_W'(Q_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/spre_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_predictive_residual_encoder_assert.svh"

module spre_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           pop_valid_i,
  output logic                pop_ready_o,
  input  wire spre_pkg::job_t pop_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output spre_pkg::out_item_t out_data_o
);
  import spre_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  function automatic logic [PARAM_W-1:0] sat_param(input logic [NUM_W-1:0] q);
    logic [PARAM_W-1:0] p;
    if (q == '0) begin
      p = PARAM_MIN;
    end else if (|q[NUM_W-1:PARAM_W]) begin
      p = PARAM_MAX;
    end else begin
      p = q[PARAM_W-1:0];
    end
    return p;
  endfunction

  back_state_e      state_q;
  back_state_e      state_d;
  logic [CNT_W-1:0] cnt_q;
  job_t             job_q;
  logic [NUM_W-1:0] num_q [2];
  logic [DEN_W-1:0] rem_q [2];
  logic [NUM_W-1:0] quo_q [2];
  logic [DEN_W-1:0] den_q;
  logic             out_valid_q;
  out_item_t        out_data_q;

  logic             out_free;
  logic             load_div;
  logic             out_load;
  logic [NUM_W-1:0] num_init [2];
  logic [DEN_W-1:0] den_init;
  logic [DEN_W:0]   shifted [2];
  logic [DEN_W:0]   diff [2];
  logic             ge [2];
  out_item_t        out_d;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (pop_valid_i && pop_data_i.use_div) state_d = BK_DIV;
      BK_DIV:  if (cnt_q == CNT_W'(1)) state_d = BK_OUT;
      BK_OUT:  if (out_free) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_ready_o = 1'b0;
    load_div    = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        pop_ready_o = pop_data_i.use_div || out_free;
        load_div    = pop_valid_i && pop_data_i.use_div;
        out_load    = pop_valid_i && !pop_data_i.use_div && out_free;
      end
      BK_OUT:  out_load = out_free;
      default: ;
    endcase
  end

  // Restoring division, one quotient bit per cycle in each of the two lanes.
  always_comb begin
    num_init[0] = NUM_W'({pop_data_i.first_sum, 4'b0}) + NUM_W'({pop_data_i.first_sum, 1'b0})
                + NUM_W'(pop_data_i.first_sum);
    num_init[1] = NUM_W'({pop_data_i.second_sum, 4'b0})
                + NUM_W'({pop_data_i.second_sum, 1'b0}) + NUM_W'(pop_data_i.second_sum);
    den_init    = DEN_W'({pop_data_i.len, 4'b0}) + DEN_W'({pop_data_i.len, 2'b0});
    for (int i = 0; i < 2; i++) begin
      shifted[i] = {rem_q[i], num_q[i][NUM_W-1]};
      diff[i]    = shifted[i] - {1'b0, den_q};
      ge[i]      = (shifted[i] >= {1'b0, den_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_div) begin
      job_q <= pop_data_i;
      den_q <= den_init;
      for (int i = 0; i < 2; i++) begin
        num_q[i] <= num_init[i];
        rem_q[i] <= '0;
        quo_q[i] <= '0;
      end
    end else if (state_q == BK_DIV) begin
      for (int i = 0; i < 2; i++) begin
        num_q[i] <= {num_q[i][NUM_W-2:0], 1'b0};
        rem_q[i] <= ge[i] ? diff[i][DEN_W-1:0] : shifted[i][DEN_W-1:0];
        quo_q[i] <= {quo_q[i][NUM_W-2:0], ge[i]};
      end
    end
  end

  always_comb begin
    if (state_q == BK_OUT) begin
      out_d.first_residual  = job_q.first_residual;
      out_d.second_residual = job_q.second_residual;
      out_d.block_end       = 1'b1;
      out_d.first_param     = sat_param(quo_q[0]);
      out_d.second_param    = sat_param(quo_q[1]);
    end else begin
      out_d.first_residual  = pop_data_i.first_residual;
      out_d.second_residual = pop_data_i.second_residual;
      out_d.block_end       = pop_data_i.closes;
      out_d.first_param     = pop_data_i.closes ? pop_data_i.fixed_param : '0;
      out_d.second_param    = pop_data_i.closes ? pop_data_i.fixed_param : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_div) begin
        cnt_q <= CNT_W'(NUM_W);
      end else if (state_q == BK_DIV) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, out_load, out_free, "result overwritten")
  `ASSERT_IMPL(a_div_count, clk_i, rst_ni, state_q == BK_DIV, cnt_q != '0, "bad div count")
  `ASSERT_NEXT(a_div_start, clk_i, rst_ni, load_div,
               state_q == BK_DIV && cnt_q == CNT_W'(NUM_W), "division not started")
  `ASSERT_NEXT(a_div_finish, clk_i, rst_ni, state_q == BK_DIV && cnt_q == CNT_W'(1),
               state_q == BK_OUT, "division not finished")

endmodule

`default_nettype wire

// ===== src/stereo_predictive_residual_encoder.sv =====
// Flow: an accepted pair is queued, then the back end registers it as the result; a
// pair closing a block with the adaptive parameter goes: pop, 37 divider steps, load.
// Throughput: one pair per cycle while the output is not stalled, except that a block
// close with the adaptive parameter holds the back end while a 2-entry queue buffers.
// Reset: asynchronous, active low; clears histories, sums, counters, queue
// and output valid, and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module stereo_predictive_residual_encoder #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire spre_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output spre_pkg::out_item_t      out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [15:0]         cfg_data_i
);
  import spre_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;
  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic pop_valid;
  logic pop_ready;
  job_t pop_job;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_PREDICTOR_MODE: cfg_d.predictor_mode = cfg_data_i[2:0];
        CFG_CHANNEL_MODE:   cfg_d.channel_mode   = cfg_data_i[1:0];
        CFG_ADAPTIVE_PARAM: cfg_d.adaptive_param = cfg_data_i[0];
        CFG_FIXED_PARAM:    cfg_d.fixed_param    = cfg_data_i;
        CFG_BLOCK_LENGTH:   cfg_d.block_length   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.predictor_mode <= PREDICTOR_MODE_RESET;
      cfg_q.channel_mode   <= CHANNEL_MODE_RESET;
      cfg_q.adaptive_param <= ADAPTIVE_PARAM_RESET;
      cfg_q.fixed_param    <= FIXED_PARAM_RESET;
      cfg_q.block_length   <= BLOCK_LENGTH_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_stall_o = !push_ready;

  spre_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .job_o       (push_job)
  );

  spre_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_job),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_job)
  );

  spre_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_data_i (pop_job),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire
